// ===== rtl/tmo_pkg.sv =====
package tmo_pkg;

    localparam int ChanW  = 24;
    localparam int RegW   = 16;
    localparam int OutW   = 17;
    localparam int ProdW  = ChanW + RegW;
    localparam int LumaW  = ProdW + 2 - 16;
    localparam int QuoW   = ChanW;
    localparam int NumW   = ChanW + 16;
    localparam int DenTvW = ChanW + 1;
    localparam int DenInW = LumaW + 1;
    localparam int CfgIdxW = 4;

    // front (2) + luma merge (1) + divider (QuoW) + product (1) + output (1)
    localparam int Latency = 3 + QuoW + 2;

    localparam logic [RegW-1:0] GainRst   = 16'd4096;
    localparam logic [RegW-1:0] CoeffRRst = 16'd13933;
    localparam logic [RegW-1:0] CoeffGRst = 16'd46871;
    localparam logic [RegW-1:0] CoeffBRst = 16'd4732;

    localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};
    localparam logic [OutW-1:0]  OutMax  = {OutW{1'b1}};

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN    = 4'd0,
        CFG_COEFF_R = 4'd1,
        CFG_COEFF_G = 4'd2,
        CFG_COEFF_B = 4'd3
    } t_cfg_idx;

endpackage

// ===== rtl/tmo_div.sv =====
module tmo_div #(
    parameter int NW = 40,
    parameter int DW = 27,
    parameter int QW = 24
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int CW = DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [CW-1:0] w_sh;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_quo = r_quo[s-1];
        end

        assign w_sh = CW'(w_den) << (QW - 1 - s);

        always_comb begin
            n_rem = w_rem;
            n_quo = w_quo;
            if (w_sh <= CW'(w_rem)) begin
                n_rem = NW'(CW'(w_rem) - w_sh);
                n_quo[QW-1-s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= w_den;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

// ===== rtl/tmo_lane_front.sv =====
module tmo_lane_front
    import tmo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ChanW-1:0] i_x,
    input  logic [RegW-1:0]  i_gain,
    input  logic [RegW-1:0]  i_coeff,
    output logic [ProdW-1:0] o_prod,
    output logic [ChanW-1:0] o_c
);
    logic [ProdW-1:0] w_scaled;
    logic [ProdW-13:0] w_shift;
    logic [ChanW-1:0] n_c;
    logic [ChanW-1:0] r_c;
    logic [ChanW-1:0] r_cb;
    logic [ChanW-1:0] r_cc;
    logic [ProdW-1:0] r_prod;

    assign w_scaled = ProdW'(i_x) * ProdW'(i_gain);
    assign w_shift  = w_scaled[ProdW-1:12];
    assign n_c = (w_shift > (ProdW-12)'(ChanMax)) ? ChanMax : w_shift[ChanW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_prod <= ProdW'(r_c) * ProdW'(i_coeff);
            r_cb   <= r_c;
            r_cc   <= r_cb;
        end
    end

    assign o_prod = r_prod;
    assign o_c    = r_cc;
endmodule

// ===== rtl/tmo_luma.sv =====
module tmo_luma
    import tmo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ProdW-1:0] i_prod_r,
    input  logic [ProdW-1:0] i_prod_g,
    input  logic [ProdW-1:0] i_prod_b,
    output logic [LumaW-1:0] o_luma
);
    logic [ProdW+1:0] w_sum;
    logic [LumaW-1:0] r_luma;

    assign w_sum = (ProdW+2)'(i_prod_r) + (ProdW+2)'(i_prod_g) + (ProdW+2)'(i_prod_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma <= w_sum[ProdW+1:16];
        end
    end

    assign o_luma = r_luma;
endmodule

// ===== rtl/tmo_lane_back.sv =====
module tmo_lane_back
    import tmo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ChanW-1:0] i_c,
    input  logic [LumaW-1:0] i_luma,
    output logic [OutW-1:0]  o_out
);
    localparam int MulW = ChanW + 17;
    localparam int SumW = MulW + 1;

    logic [NumW-1:0]   w_num;
    logic [DenTvW-1:0] w_den_tv;
    logic [DenInW-1:0] w_den_in;
    logic [QuoW-1:0]   w_tv;
    logic [QuoW-1:0]   w_in;
    logic [16:0]       w_inv_tv;
    logic [MulW-1:0]   r_p_in;
    logic [31:0]       r_p_tv;
    logic [SumW-1:0]   w_sum;
    logic [SumW-17:0]  w_res;
    logic [OutW-1:0]   r_out;

    assign w_num    = {i_c, 16'd0};
    assign w_den_tv = DenTvW'(i_c) + DenTvW'(17'h10000);
    assign w_den_in = DenInW'(i_luma) + DenInW'(17'h10000);

    tmo_div #(.NW(NumW), .DW(DenTvW), .QW(QuoW)) u_div_tv (
        .i_clk (i_clk), .i_en (i_en), .i_num (w_num), .i_den (w_den_tv), .o_quo (w_tv)
    );

    tmo_div #(.NW(NumW), .DW(DenInW), .QW(QuoW)) u_div_in (
        .i_clk (i_clk), .i_en (i_en), .i_num (w_num), .i_den (w_den_in), .o_quo (w_in)
    );

    // tv stays below 1.0, so its low 16 bits carry the whole value
    assign w_inv_tv = 17'h10000 - {1'b0, w_tv[15:0]};

    assign w_sum = SumW'(r_p_in) + SumW'(r_p_tv);
    assign w_res = w_sum[SumW-1:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_in <= MulW'(w_in) * MulW'(w_inv_tv);
            r_p_tv <= 32'(w_tv[15:0]) * 32'(w_tv[15:0]);
            r_out  <= (w_res > (SumW-16)'(OutMax)) ? OutMax : w_res[OutW-1:0];
        end
    end

    assign o_out = r_out;
endmodule

// ===== rtl/reinhard_jodie_tone_map.sv =====
// Reinhard-Jodie tone mapper: one linear Q8.16 RGB pixel in, one Q1.16 RGB pixel out.
// Fully pipelined, one pixel per clock sustained while the output is not stalled; most
// of the depth comes from the two 24-stage restoring dividers in each channel lane.
// The whole pipeline advances whenever the output register is empty or being taken, so
// a stalled output holds every stage. Configuration writes are always ready; the gain
// applies to pixels accepted afterwards; write them only while the pipeline is empty.
module reinhard_jodie_tone_map
    import tmo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ChanW-1:0]   i_red_in,
    input  logic [ChanW-1:0]   i_green_in,
    input  logic [ChanW-1:0]   i_blue_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OutW-1:0]    o_red_out,
    output logic [OutW-1:0]    o_green_out,
    output logic [OutW-1:0]    o_blue_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [RegW-1:0]    i_cfg_data
);
    logic [RegW-1:0]    r_gain;
    logic [RegW-1:0]    r_coeff_r;
    logic [RegW-1:0]    r_coeff_g;
    logic [RegW-1:0]    r_coeff_b;
    logic [Latency-1:0] r_vld;
    logic               w_en;
    logic [ProdW-1:0]   w_prod_r, w_prod_g, w_prod_b;
    logic [ChanW-1:0]   w_c_r, w_c_g, w_c_b;
    logic [LumaW-1:0]   w_luma;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GainRst;
            r_coeff_r <= CoeffRRst;
            r_coeff_g <= CoeffGRst;
            r_coeff_b <= CoeffBRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN:    r_gain    <= i_cfg_data;
                CFG_COEFF_R: r_coeff_r <= i_cfg_data;
                CFG_COEFF_G: r_coeff_g <= i_cfg_data;
                CFG_COEFF_B: r_coeff_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance everything unless the finished result is stalled
    assign w_en       = !r_vld[Latency-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[Latency-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Latency-2:0], i_in_valid};
        end
    end

    tmo_lane_front u_front_r (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_red_in), .i_gain (r_gain),
        .i_coeff (r_coeff_r), .o_prod (w_prod_r), .o_c (w_c_r)
    );
    tmo_lane_front u_front_g (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_green_in), .i_gain (r_gain),
        .i_coeff (r_coeff_g), .o_prod (w_prod_g), .o_c (w_c_g)
    );
    tmo_lane_front u_front_b (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_blue_in), .i_gain (r_gain),
        .i_coeff (r_coeff_b), .o_prod (w_prod_b), .o_c (w_c_b)
    );

    tmo_luma u_luma (
        .i_clk (i_clk), .i_en (w_en), .i_prod_r (w_prod_r), .i_prod_g (w_prod_g),
        .i_prod_b (w_prod_b), .o_luma (w_luma)
    );

    tmo_lane_back u_back_r (
        .i_clk (i_clk), .i_en (w_en), .i_c (w_c_r), .i_luma (w_luma), .o_out (o_red_out)
    );
    tmo_lane_back u_back_g (
        .i_clk (i_clk), .i_en (w_en), .i_c (w_c_g), .i_luma (w_luma), .o_out (o_green_out)
    );
    tmo_lane_back u_back_b (
        .i_clk (i_clk), .i_en (w_en), .i_c (w_c_b), .i_luma (w_luma), .o_out (o_blue_out)
    );
endmodule

// ===== rtl/tmo_checker.sv =====
module tmo_checker
    import tmo_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [OutW-1:0] o_red_out,
    input logic [OutW-1:0] o_green_out,
    input logic [OutW-1:0] o_blue_out
);
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready disagrees with output stall");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out))
        else $error("stalled result transaction changed");
endmodule

bind reinhard_jodie_tone_map tmo_checker u_tmo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
